@@ rtl/core/sqs_pkg.sv @@
package sqs_pkg;

   // default width of the arrival and departure counters that take part in the load grade
   localparam int unsigned COUNT_BITS_DEFAULT = 16;

   localparam int unsigned ID_W     = 8;
   localparam int unsigned SIZE_W   = 16;
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned HEALTH_W = 2;
   localparam int unsigned PRIO_W   = 2;
   localparam int unsigned SCORE_W  = 7;
   localparam int unsigned SUM_W    = 8;

   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic [ID_W-1:0]     queue_id;
      logic [SIZE_W-1:0]   backlog;
      logic [CNT_W-1:0]    arrivals;
      logic [CNT_W-1:0]    departures;
      logic [HEALTH_W-1:0] health;
      logic [PRIO_W-1:0]   prio_level;
      logic                last;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]    best_queue_id;
      logic [SCORE_W-1:0] best_score;
   } rsp_payload_type;

   // scored candidate handed from the front stage to the running best
   typedef struct packed {
      logic [ID_W-1:0]    queue_id;
      logic [SCORE_W-1:0] score;
      logic               last;
   } cand_type;

   typedef enum logic [1:0] {
      GRADE_LOW,
      GRADE_MED,
      GRADE_HIGH
   } grade_type;

   localparam logic [HEALTH_W-1:0] HEALTH_GOOD     = 2'd0;
   localparam logic [HEALTH_W-1:0] HEALTH_DEGRADED = 2'd1;
   localparam logic [PRIO_W-1:0]   PRIO_HIGH       = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_LOW_MAX = 16'd2;
   localparam logic [SIZE_W-1:0] SIZE_MED_MAX = 16'd6;

   // score steps in hundredths
   localparam sum_type SCORE_BASE       = 8'sd50;
   localparam sum_type STEP_SIZE_LOW    = 8'sd25;
   localparam sum_type STEP_SIZE_MED    = 8'sd5;
   localparam sum_type STEP_SIZE_HIGH   = -8'sd30;
   localparam sum_type STEP_LOAD_LOW    = 8'sd20;
   localparam sum_type STEP_LOAD_MED    = 8'sd5;
   localparam sum_type STEP_LOAD_HIGH   = -8'sd30;
   localparam sum_type STEP_HEALTH_GOOD = 8'sd20;
   localparam sum_type STEP_HEALTH_DEG  = -8'sd15;
   localparam sum_type STEP_HEALTH_BAD  = -8'sd60;
   localparam sum_type PEN_PRIO_SIZE    = -8'sd10;
   localparam sum_type PEN_PRIO_LOAD    = -8'sd20;
   localparam sum_type PEN_PRIO_HEALTH  = -8'sd20;
   localparam sum_type SCORE_MAX_S      = 8'sd100;

   localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
   localparam logic [SCORE_W-1:0] SCORE_MIN = 7'd0;

endpackage

@@ rtl/core/sqs_channels.sv @@
interface sqs_req_if;
   import sqs_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sqs_rsp_if;
   import sqs_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sqs_score.sv @@
module sqs_score #(
   parameter int unsigned COUNT_BITS = sqs_pkg::COUNT_BITS_DEFAULT
) (
   input  sqs_pkg::req_payload_type      item,
   output logic [sqs_pkg::SCORE_W-1:0]   score
);
   import sqs_pkg::*;

   localparam int unsigned EFF_W  = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
   localparam int unsigned PROD_W = EFF_W + 3;

   logic [EFF_W-1:0]  arr_c;
   logic [EFF_W-1:0]  dep_c;
   logic [PROD_W-1:0] arr_w;
   logic [PROD_W-1:0] dep_w;
   logic [PROD_W-1:0] arr_x5;
   logic [PROD_W-1:0] dep_x4;
   logic [PROD_W-1:0] dep_x6;
   grade_type         size_grade;
   grade_type         load_grade;
   sum_type           acc;

   assign arr_c  = item.arrivals[EFF_W-1:0];
   assign dep_c  = item.departures[EFF_W-1:0];
   assign arr_w  = {3'b000, arr_c};
   assign dep_w  = {3'b000, dep_c};
   assign arr_x5 = (arr_w << 2) + arr_w;
   assign dep_x4 = dep_w << 2;
   assign dep_x6 = (dep_w << 2) + (dep_w << 1);

   always_comb begin
      if (item.backlog <= SIZE_LOW_MAX) begin
         size_grade = GRADE_LOW;
      end else if (item.backlog <= SIZE_MED_MAX) begin
         size_grade = GRADE_MED;
      end else begin
         size_grade = GRADE_HIGH;
      end
   end

   // ratio compare without division, empty departures handled apart
   always_comb begin
      if (dep_c == '0) begin
         load_grade = (arr_c != '0) ? GRADE_HIGH : GRADE_LOW;
      end else if (arr_x5 < dep_x4) begin
         load_grade = GRADE_LOW;
      end else if (arr_x5 <= dep_x6) begin
         load_grade = GRADE_MED;
      end else begin
         load_grade = GRADE_HIGH;
      end
   end

   always_comb begin
      acc = SCORE_BASE;
      case (size_grade)
         GRADE_LOW: acc = acc + STEP_SIZE_LOW;
         GRADE_MED: acc = acc + STEP_SIZE_MED;
         default:   acc = acc + STEP_SIZE_HIGH;
      endcase
      case (load_grade)
         GRADE_LOW: acc = acc + STEP_LOAD_LOW;
         GRADE_MED: acc = acc + STEP_LOAD_MED;
         default:   acc = acc + STEP_LOAD_HIGH;
      endcase
      // unused health code counts as bad
      case (item.health)
         HEALTH_GOOD:     acc = acc + STEP_HEALTH_GOOD;
         HEALTH_DEGRADED: acc = acc + STEP_HEALTH_DEG;
         default:         acc = acc + STEP_HEALTH_BAD;
      endcase
      if (item.prio_level == PRIO_HIGH) begin
         if (size_grade != GRADE_LOW) begin
            acc = acc + PEN_PRIO_SIZE;
         end
         if (load_grade == GRADE_HIGH) begin
            acc = acc + PEN_PRIO_LOAD;
         end
         if (item.health != HEALTH_GOOD) begin
            acc = acc + PEN_PRIO_HEALTH;
         end
      end
   end

   always_comb begin
      if (acc < 0) begin
         score = SCORE_MIN;
      end else if (acc > SCORE_MAX_S) begin
         score = SCORE_MAX;
      end else begin
         score = acc[SCORE_W-1:0];
      end
   end

endmodule

@@ rtl/core/sqs_best.sv @@
module sqs_best (
   input  logic              clock,
   input  logic              reset,
   input  logic              cand_fire,
   input  sqs_pkg::cand_type cand,
   output logic              out_room,
   sqs_rsp_if.source         rsp_chan
);
   import sqs_pkg::*;

   logic               have_ff;
   logic               have_in;
   logic [SCORE_W-1:0] best_score_ff;
   logic [SCORE_W-1:0] best_score_in;
   logic [ID_W-1:0]    best_id_ff;
   logic [ID_W-1:0]    best_id_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_payload_type    rsp_payload_ff;
   rsp_payload_type    rsp_payload_in;
   logic               take;
   logic [SCORE_W-1:0] win_score;
   logic [ID_W-1:0]    win_id;

   // strict compare keeps the earlier candidate on a tie
   assign take      = !have_ff || (cand.score > best_score_ff);
   assign win_score = take ? cand.score : best_score_ff;
   assign win_id    = take ? cand.queue_id : best_id_ff;
   assign out_room  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      have_in        = have_ff;
      best_score_in  = best_score_ff;
      best_id_in     = best_id_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      if (cand_fire) begin
         if (cand.last) begin
            have_in                      = 1'b0;
            best_score_in                = '0;
            best_id_in                   = '0;
            rsp_valid_in                 = 1'b1;
            rsp_payload_in.best_queue_id = win_id;
            rsp_payload_in.best_score    = win_score;
         end else begin
            have_in       = 1'b1;
            best_score_in = win_score;
            best_id_in    = win_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff       <= 1'b0;
         best_score_ff <= '0;
         best_id_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         have_ff       <= have_in;
         best_score_ff <= best_score_in;
         best_id_ff    <= best_id_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

@@ rtl/core/scored_queue_selector.sv @@
// scored_queue_selector: picks the best of a job's candidate queues
//
// req_chan carries one candidate per transaction (id, length, arrival and
// departure counts, health, job priority, last). rsp_chan carries one
// transaction per job, the best id and its score in hundredths, sent when
// the candidate marked last has been taken in.
//
// a candidate accepted into the input register is scored from it and
// folded into the running best as it leaves; for a last candidate the
// result register is loaded as it leaves and then drives rsp_chan.
// throughput: one candidate per cycle unless a last candidate waits for
// the result register; the input register feeds score and compare logic.
//
// reset clears the input stage, the running best and the result valid.
// when the receiver stalls, non-last candidates keep flowing into the
// running best; a last candidate waits in the input register until the
// result register is free, and req_chan.ready stays low while it waits.
module scored_queue_selector #(
   parameter int unsigned COUNT_BITS = sqs_pkg::COUNT_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sqs_req_if.sink    req_chan,
   sqs_rsp_if.source  rsp_chan
);
   import sqs_pkg::*;

   // input stage
   logic               s1_valid_ff;
   logic               s1_valid_in;
   req_payload_type    s1_item_ff;
   logic               req_take;
   logic               s1_fire;
   logic               out_room;
   logic [SCORE_W-1:0] s1_score;
   cand_type           cand;

   // a last candidate needs a free result slot, others never wait
   assign s1_fire        = s1_valid_ff && (!s1_item_ff.last || out_room);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload holds while the stage waits
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_chan.payload;
      end
   end

   // grading and scoring of the registered candidate
   sqs_score #(
      .COUNT_BITS (COUNT_BITS)
   ) u_score (
      .item  (s1_item_ff),
      .score (s1_score)
   );

   assign cand.queue_id = s1_item_ff.queue_id;
   assign cand.score    = s1_score;
   assign cand.last     = s1_item_ff.last;

   // running best and result register
   sqs_best u_best (
      .clock     (clock),
      .reset     (reset),
      .cand_fire (s1_fire),
      .cand      (cand),
      .out_room  (out_room),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import sqs_pkg::*;

   // codes the package leaves unnamed
   localparam logic [HEALTH_W-1:0] HEALTH_BAD   = 2'd2;
   localparam logic [HEALTH_W-1:0] HEALTH_CODE3 = 2'd3;  // reads as bad
   localparam logic [PRIO_W-1:0]   PRIO_LOW     = 2'd0;
   localparam logic [PRIO_W-1:0]   PRIO_MED     = 2'd1;
   localparam logic [PRIO_W-1:0]   PRIO_CODE3   = 2'd3;  // reads as low

   localparam int IDLE_PERCENT  = 35;
   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
   localparam int SETTLE_CYCLES = 6;
   localparam int ITEM_TARGET   = 1800;

   logic clock;
   logic reset;

   sqs_req_if req_bus();
   sqs_rsp_if rsp_bus();

   scored_queue_selector u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shared run state
   bit              calm;          // when set neither side idles
   int              mismatches;
   int              items_sent;
   int              stalled_cycles;
   rsp_payload_type pending_best[$];

   // predictor copy of the running best
   logic [SCORE_W-1:0] best_score_model;
   logic [ID_W-1:0]    best_id_model;
   bit                 have_candidate_model;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // scoring of one candidate, in hundredths, clamped to 0..100
   // ------------------------------------------------------------------
   function automatic logic [SCORE_W-1:0] candidate_score(input req_payload_type c);
      grade_type   len_grade;
      grade_type   load_grade;
      int unsigned arr;
      int unsigned dep;
      bit          health_good;
      bit          health_degraded;
      bit          urgent;
      int          s;

      arr = 32'(c.arrivals);
      dep = 32'(c.departures);

      if (c.backlog <= 2)      len_grade = GRADE_LOW;
      else if (c.backlog <= 6) len_grade = GRADE_MED;
      else                     len_grade = GRADE_HIGH;

      // ratio against 0.8 and 1.2 by cross multiplication, no departures is special
      if (dep == 0)                load_grade = (arr != 0) ? GRADE_HIGH : GRADE_LOW;
      else if (5 * arr < 4 * dep)  load_grade = GRADE_LOW;
      else if (5 * arr <= 6 * dep) load_grade = GRADE_MED;
      else                         load_grade = GRADE_HIGH;

      // health code 3 falls in with bad, priority code 3 with low
      health_good     = (c.health == HEALTH_GOOD);
      health_degraded = (c.health == HEALTH_DEGRADED);
      urgent          = (c.prio_level == PRIO_HIGH);

      s = 50;
      case (len_grade)
         GRADE_LOW: s += 25;
         GRADE_MED: s += 5;
         default:   s -= 30;
      endcase
      case (load_grade)
         GRADE_LOW: s += 20;
         GRADE_MED: s += 5;
         default:   s -= 30;
      endcase
      if (health_good)          s += 20;
      else if (health_degraded) s -= 15;
      else                      s -= 60;

      if (urgent) begin
         if (len_grade != GRADE_LOW)   s -= 10;
         if (load_grade == GRADE_HIGH) s -= 20;
         if (!health_good)             s -= 20;
      end

      if (s < 0)   s = 0;
      if (s > 100) s = 100;
      return SCORE_W'(s);
   endfunction

   // fold an accepted candidate into the running best, queue the job's winner on last
   task automatic fold_candidate(input req_payload_type c);
      logic [SCORE_W-1:0] s;
      rsp_payload_type    winner;

      s = candidate_score(c);
      // strict compare keeps the earlier candidate on equal scores
      if (!have_candidate_model || s > best_score_model) begin
         best_score_model     = s;
         best_id_model        = c.queue_id;
         have_candidate_model = 1'b1;
      end
      if (c.last) begin
         winner.best_queue_id = best_id_model;
         winner.best_score    = best_score_model;
         pending_best.push_back(winner);
         best_score_model     = '0;
         best_id_model        = '0;
         have_candidate_model = 1'b0;
      end
   endtask

   task automatic report_error(input string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // sender: optional idle cycles, then hold valid until the transaction
   // goes through; valid stays high into the next candidate unless that
   // one starts with idle cycles
   task automatic send_candidate(input req_payload_type c);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= c;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      fold_candidate(c);
      items_sent++;
   endtask

   // called right after a transaction edge: drop valid and let the results drain
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_best.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_payload_type make_candidate(
      input int id, input int size, input int arr, input int dep,
      input logic [HEALTH_W-1:0] health, input logic [PRIO_W-1:0] prio, input bit last_flag);
      req_payload_type c;

      c.queue_id   = ID_W'(id);
      c.backlog    = SIZE_W'(size);
      c.arrivals   = CNT_W'(arr);
      c.departures = CNT_W'(dep);
      c.health     = health;
      c.prio_level = prio;
      c.last       = last_flag;
      return c;
   endfunction

   // random candidate, weighted toward the grade edges
   function automatic req_payload_type random_candidate(input bit last_flag);
      req_payload_type c;
      int              k;
      int              arr;
      int              dep;

      c.queue_id = ID_W'($urandom_range(255));
      case ($urandom_range(3))
         0, 1:    c.backlog = SIZE_W'($urandom_range(8));
         2:       c.backlog = SIZE_W'($urandom_range(16));
         default: c.backlog = SIZE_W'($urandom_range(65535));
      endcase

      case ($urandom_range(5))
         0: begin
            arr = $urandom_range(65535);
            dep = $urandom_range(65535);
         end
         1: begin
            // nothing departed
            dep = 0;
            arr = $urandom_range(1) ? $urandom_range(65535) : 0;
         end
         2: begin
            // around the 0.8 edge
            k   = $urandom_range(1, 13107);
            dep = 5 * k;
            arr = 4 * k + $urandom_range(2) - 1;
         end
         3: begin
            // around the 1.2 edge
            k   = $urandom_range(1, 10922);
            dep = 5 * k;
            arr = 6 * k + $urandom_range(2) - 1;
         end
         4: begin
            arr = $urandom_range(20);
            dep = $urandom_range(20);
         end
         default: begin
            arr = $urandom_range(65535);
            dep = $urandom_range(1) ? 65535 : $urandom_range(20);
         end
      endcase
      c.arrivals   = CNT_W'(arr);
      c.departures = CNT_W'(dep);
      c.health     = HEALTH_W'($urandom_range(3));
      c.prio_level = PRIO_W'($urandom_range(3));
      c.last       = last_flag;
      return c;
   endfunction

   task automatic send_job(input int len);
      for (int i = 0; i < len; i++) begin
         send_candidate(random_candidate(i == len - 1));
      end
   endtask

   // ------------------------------------------------------------------
   // result side: ready idles at random, every transaction is checked
   // field by field against the oldest queued winner
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;

      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_best.size() == 0) begin
            report_error($sformatf("result with none pending: id %0d score %0d",
                                   rsp_bus.payload.best_queue_id,
                                   rsp_bus.payload.best_score));
         end else begin
            want = pending_best.pop_front();
            if (rsp_bus.payload.best_queue_id !== want.best_queue_id)
               report_error($sformatf("best_queue_id got %0d want %0d",
                                      rsp_bus.payload.best_queue_id, want.best_queue_id));
            if (rsp_bus.payload.best_score !== want.best_score)
               report_error($sformatf("best_score got %0d want %0d",
                                      rsp_bus.payload.best_score, want.best_score));
         end
      end
   end

   // watchdog: a run that stops moving ends as a failure
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
                     $realtime, STALL_LIMIT, pending_best.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // grade edges, score clamps, no-departure cases, odd health and priority codes
   task automatic test_grade_edges();
      calm = 1'b0;
      // single candidate job at the top clamp: 115 folds to 100
      send_candidate(make_candidate(0, 0, 0, 0, HEALTH_GOOD, PRIO_LOW, 1'b1));
      // bottom clamp on the first candidate, which still becomes the best
      send_candidate(make_candidate(255, 65535, 65535, 0, HEALTH_BAD, PRIO_HIGH, 1'b0));
      // health code 3 and priority code 3, equal score so the first stays
      send_candidate(make_candidate(1, 7, 65535, 65535, HEALTH_CODE3, PRIO_CODE3, 1'b0));
      // length 2 and load 0.6, under the 0.8 edge
      send_candidate(make_candidate(2, 2, 3, 5, HEALTH_DEGRADED, PRIO_MED, 1'b0));
      // length 3 and load exactly 0.8, same score as the one before
      send_candidate(make_candidate(3, 3, 4, 5, HEALTH_GOOD, PRIO_LOW, 1'b0));
      // length 6, load exactly 1.2, high priority
      send_candidate(make_candidate(4, 6, 6, 5, HEALTH_GOOD, PRIO_HIGH, 1'b0));
      // load just over 1.2, high priority load and health penalties
      send_candidate(make_candidate(5, 0, 7, 5, HEALTH_DEGRADED, PRIO_HIGH, 1'b1));
      // no arrivals against full departures, then arrivals with no departures
      send_candidate(make_candidate(170, 1, 0, 65535, HEALTH_GOOD, PRIO_HIGH, 1'b0));
      send_candidate(make_candidate(85, 1, 1, 0, HEALTH_GOOD, PRIO_MED, 1'b1));
      // alternating bit patterns in every field
      send_candidate(make_candidate(85, 21845, 43690, 21845, HEALTH_DEGRADED, PRIO_MED, 1'b0));
      send_candidate(make_candidate(170, 43690, 21845, 43690, HEALTH_BAD, PRIO_HIGH, 1'b1));
      wait_for_results();
   endtask

   // later candidate wins only on a strictly higher score
   task automatic test_ties_and_order();
      calm = 1'b1;
      send_candidate(make_candidate(20, 7, 10, 10, HEALTH_GOOD, PRIO_LOW, 1'b0));
      send_candidate(make_candidate(21, 8, 11, 10, HEALTH_GOOD, PRIO_LOW, 1'b0));
      send_candidate(make_candidate(22, 2, 10, 10, HEALTH_GOOD, PRIO_LOW, 1'b0));
      send_candidate(make_candidate(23, 1, 9, 10, HEALTH_GOOD, PRIO_LOW, 1'b1));
      // best falls back to the zero state between jobs
      send_candidate(make_candidate(0, 9, 1, 0, HEALTH_BAD, PRIO_HIGH, 1'b0));
      send_candidate(make_candidate(30, 9, 1, 0, HEALTH_BAD, PRIO_HIGH, 1'b1));
      send_candidate(make_candidate(31, 4, 4, 4, HEALTH_DEGRADED, PRIO_CODE3, 1'b1));
      send_candidate(make_candidate(32, 4, 4, 4, HEALTH_CODE3, PRIO_LOW, 1'b1));
      wait_for_results();
   endtask

   // long stretch with both sides always ready
   task automatic test_back_to_back();
      calm = 1'b1;
      while (items_sent < 400) send_job($urandom_range(1, 6));
      calm = 1'b0;
   endtask

   // sender holds off until every pending result is out, several times
   task automatic test_drain_pause();
      calm = 1'b0;
      for (int j = 0; j < 30; j++) begin
         send_job($urandom_range(1, 8));
         if ($urandom_range(2) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   // bulk of the run: random jobs with idling on both sides, a few long ones
   task automatic test_random_jobs();
      calm = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(19) == 0) send_job($urandom_range(9, 40));
         else                         send_job($urandom_range(1, 6));
      end
   endtask

   initial begin
      reset                = 1'b1;
      calm                 = 1'b0;
      mismatches           = 0;
      items_sent           = 0;
      stalled_cycles       = 0;
      best_score_model     = '0;
      best_id_model        = '0;
      have_candidate_model = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.payload      = '0;
      rsp_bus.ready        = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_grade_edges();
      test_ties_and_order();
      test_back_to_back();
      test_drain_pause();
      test_random_jobs();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ scored_queue_selector.f @@
rtl/core/sqs_pkg.sv
rtl/core/sqs_channels.sv
rtl/core/sqs_score.sv
rtl/core/sqs_best.sv
rtl/core/scored_queue_selector.sv
tb/sv/tb_top.sv
